@@ rtl/cdc_pkg.sv @@
// ---------------------------------------------------------------------------
// cdc_pkg: shared constants and types for the common divisor counter
// Holds the operand width default, result widths and the sequencer states.
// ---------------------------------------------------------------------------
package cdc_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned COUNT_W         = 12;
    localparam int unsigned TOTAL_W         = 13;   // holds up to COUNT_MAX + 1
    localparam int unsigned COUNT_MAX       = 4095;
    localparam int unsigned FIRST_ODD       = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_CHK,
        ST_GCD_WAIT,
        ST_TWO,
        ST_ODD_START,
        ST_ODD_WAIT,
        ST_ODD_MUL,
        ST_FINAL
    } t_cdc_state;

endpackage

@@ rtl/cdc_divider.sv @@
// ---------------------------------------------------------------------------
// cdc_divider: shared restoring divider
// One quotient bit per cycle; quotient and remainder valid with o_done.
// ---------------------------------------------------------------------------
module cdc_divider import cdc_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [VALUE_WIDTH-1:0] o_remainder
);

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_den;

    logic [VALUE_WIDTH:0]   w_shift;
    logic [VALUE_WIDTH:0]   w_diff;
    logic                   w_ge;

    // trial subtract of the divisor from the shifted partial remainder
    assign w_shift = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = ~w_diff[VALUE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VALUE_WIDTH-1:0] : w_shift[VALUE_WIDTH-1:0];
            r_quo <= {r_quo[VALUE_WIDTH-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ rtl/common_divisor_counter_top.sv @@
// ---------------------------------------------------------------------------
// common_divisor_counter_top: count of divisors shared by two operands
// Forms gcd(first, second) by Euclid, then counts its divisors by trial
// division, all on one shared restoring divider under a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_first_value / i_second_value and raise start;
//   the operands transfer at the rising edge where start is high and busy
//   is low. busy stays high until the result has been presented.
//   Result channel: o_done is high for exactly one cycle with
//   o_divisor_count and o_operand_error; the receiver cannot stall it, so
//   sample the result in that cycle.
//   A zero operand is flagged at once: o_done rises in the cycle after the
//   transfer, with o_operand_error set and a count of zero.
//   Otherwise all divisions run on the shared divider. Euclid needs at
//   most about 1.5 * VALUE_WIDTH divisions, factors of two are stripped
//   one at a time by shifting, and trial division takes one division per
//   odd candidate up to the square root of the remaining value plus one
//   per prime factor found, with a pass through ST_ODD_MUL per candidate
//   for the exponent product. For 32-bit operands the worst case is
//   roughly 32768 candidates.
//   One item is in flight at a time; the divider loop sets the rate.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   any item in progress; no result is produced for it.
// ---------------------------------------------------------------------------
module common_divisor_counter_top import cdc_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_first_value,
    input  logic [VALUE_WIDTH-1:0] i_second_value,
    output logic                   o_done,
    output logic [COUNT_W-1:0]     o_divisor_count,
    output logic                   o_operand_error
);

    localparam int unsigned E_W    = $clog2(VALUE_WIDTH + 1);
    localparam int unsigned PROD_W = TOTAL_W + E_W;

    // sequencer state and working registers
    t_cdc_state             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_x, n_x;          // Euclid dividend
    logic [VALUE_WIDTH-1:0] r_y, n_y;          // Euclid divisor
    logic [VALUE_WIDTH-1:0] r_g, n_g;          // remaining value being factored
    logic [VALUE_WIDTH-1:0] r_d, n_d;          // current odd candidate
    logic [E_W-1:0]         r_e, n_e;          // exponent of current prime
    logic                   r_first, n_first;  // first division for this candidate
    logic [TOTAL_W-1:0]     r_total, n_total;  // running product, saturates at max + 1
    logic [COUNT_W-1:0]     r_count, n_count;
    logic                   r_err, n_err;
    logic                   r_done, n_done;

    // shared divider hookup
    logic                   w_div_start;
    logic [VALUE_WIDTH-1:0] w_div_dividend;
    logic [VALUE_WIDTH-1:0] w_div_divisor;
    logic                   w_div_done;
    logic [VALUE_WIDTH-1:0] w_div_quo;
    logic [VALUE_WIDTH-1:0] w_div_rem;

    logic [PROD_W-1:0]      w_prod;
    logic [TOTAL_W:0]       w_final;

    cdc_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // Euclid divides x by y; trial division divides g by d
    assign w_div_dividend = (r_state == ST_GCD_CHK) ? r_x : r_g;
    assign w_div_divisor  = (r_state == ST_GCD_CHK) ? r_y : r_d;

    // exponent product for the candidate just finished
    assign w_prod  = PROD_W'(r_total) * PROD_W'(r_e + 1'b1);

    // a leftover above one is a prime of its own: double the product
    assign w_final = (r_g > VALUE_WIDTH'(1)) ? {r_total, 1'b0} : {1'b0, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_g     <= n_g;
        r_d     <= n_d;
        r_e     <= n_e;
        r_first <= n_first;
        r_total <= n_total;
        r_count <= n_count;
        r_err   <= n_err;
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_g         = r_g;
        n_d         = r_d;
        n_e         = r_e;
        n_first     = r_first;
        n_total     = r_total;
        n_count     = r_count;
        n_err       = r_err;
        n_done      = 1'b0;
        w_div_start = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start && !r_done) begin
                    if ((i_first_value == '0) || (i_second_value == '0)) begin
                        // zero operand: flag and report straight away
                        n_count = '0;
                        n_err   = 1'b1;
                        n_done  = 1'b1;
                    end else begin
                        n_x     = i_first_value;
                        n_y     = i_second_value;
                        n_state = ST_GCD_CHK;
                    end
                end
            end
            ST_GCD_CHK: begin
                if (r_y == '0) begin
                    // gcd found in x: start stripping factors of two
                    n_g     = r_x;
                    n_e     = '0;
                    n_state = ST_TWO;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT: begin
                if (w_div_done) begin
                    n_x     = r_y;
                    n_y     = w_div_rem;
                    n_state = ST_GCD_CHK;
                end
            end
            ST_TWO: begin
                if (!r_g[0]) begin
                    n_g = {1'b0, r_g[VALUE_WIDTH-1:1]};
                    n_e = r_e + 1'b1;
                end else begin
                    n_total = TOTAL_W'(r_e) + TOTAL_W'(1);
                    n_e     = '0;
                    n_d     = VALUE_WIDTH'(FIRST_ODD);
                    n_first = 1'b1;
                    n_state = ST_ODD_START;
                end
            end
            ST_ODD_START: begin
                w_div_start = 1'b1;
                n_state     = ST_ODD_WAIT;
            end
            ST_ODD_WAIT: begin
                if (w_div_done) begin
                    if (r_first && (r_d > w_div_quo)) begin
                        // candidate above the square root: stop searching
                        n_state = ST_FINAL;
                    end else if (w_div_rem == '0) begin
                        n_e     = r_e + 1'b1;
                        n_g     = w_div_quo;
                        n_first = 1'b0;
                        n_state = ST_ODD_START;
                    end else begin
                        n_state = ST_ODD_MUL;
                    end
                end
            end
            ST_ODD_MUL: begin
                if (w_prod > PROD_W'(COUNT_MAX)) begin
                    n_total = TOTAL_W'(COUNT_MAX + 1);
                end else begin
                    n_total = w_prod[TOTAL_W-1:0];
                end
                n_d     = r_d + VALUE_WIDTH'(2);
                n_e     = '0;
                n_first = 1'b1;
                n_state = ST_ODD_START;
            end
            ST_FINAL: begin
                if (w_final > (TOTAL_W + 1)'(COUNT_MAX)) begin
                    n_count = COUNT_W'(COUNT_MAX);
                end else begin
                    n_count = w_final[COUNT_W-1:0];
                end
                n_err   = 1'b0;
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // busy covers the work and the cycle in which the result is shown
    assign busy            = (r_state != ST_IDLE) || r_done;
    assign o_done          = r_done;
    assign o_divisor_count = r_count;
    assign o_operand_error = r_err;

endmodule

@@ rtl/cdc_checker.sv @@
// ---------------------------------------------------------------------------
// cdc_checker: port-level checks for the common divisor counter
// Watches the command and result channels of the top level only.
// ---------------------------------------------------------------------------
module cdc_checker import cdc_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_first_value,
    input  logic [VALUE_WIDTH-1:0] i_second_value,
    input  logic                   o_done,
    input  logic [COUNT_W-1:0]     o_divisor_count,
    input  logic                   o_operand_error
);

    // a transfer makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a command transfer");

    // a zero operand is reported in the very next cycle
    a_zero_operand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_first_value == '0) || (i_second_value == '0)))
        |=> (o_done && o_operand_error))
        else $error("zero operand not flagged in the next cycle");

    // an error result carries a count of zero, a good one at least one
    a_error_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_operand_error ? (o_divisor_count == '0)
                                    : (o_divisor_count != '0)))
        else $error("divisor count inconsistent with error flag");

    // after a result the block is free and o_done has dropped
    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("block still busy after presenting a result");

endmodule

bind common_divisor_counter_top cdc_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_cdc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_first_value   (i_first_value),
    .i_second_value  (i_second_value),
    .o_done          (o_done),
    .o_divisor_count (o_divisor_count),
    .o_operand_error (o_operand_error)
);
